### hw/rtl/hale_pkg.sv
// ----------------------------------------------------------------------------
// hale_pkg: shared types, character codes and the comp lookup table
// Types and constants used by the assembly line encoder and its submodules.
// ----------------------------------------------------------------------------
package hale_pkg;

    // default characters kept per token, and characters the encoder looks at
    localparam int TOKEN_CHARS_DEF = 3;
    localparam int LOOK_CHARS      = 3;
    localparam int NUM_TOKENS      = 3;

    localparam logic [15:0] FIXED_WORD = 16'hEA87;
    localparam logic [15:0] C_PREFIX   = 16'hE000;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] LINE_LO  = 8'd48;
    localparam logic [7:0] LINE_HI  = 8'd90;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_SKIP  = 3'd1,
        MODE_ADDR  = 3'd2,
        MODE_FIXED = 3'd3,
        MODE_CINST = 3'd4
    } line_mode_t;

    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_SPACE = 2'd1,
        PH_WORD  = 2'd2,
        PH_AFTER = 2'd3
    } token_phase_t;

    // one character held in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } char_item_t;

    // what the encoder sees of the current line's tokens
    typedef struct packed {
        logic [NUM_TOKENS-1:0][LOOK_CHARS-1:0][7:0] ch;
        logic [1:0]                                 count;
        logic                                       open;
    } tok_view_t;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [1:0] len;
        logic [5:0] code;
        logic       abit;
    } comp_entry_t;

    typedef struct packed {
        logic       hit;
        logic       abit;
        logic [5:0] code;
    } comp_hit_t;

    localparam int COMP_ENTRIES = 28;

    localparam comp_entry_t COMP_TABLE [COMP_ENTRIES] = '{
        '{CH_ZERO,  CH_NUL,   CH_NUL,  2'd1, 6'h2A, 1'b0},
        '{CH_ONE,   CH_NUL,   CH_NUL,  2'd1, 6'h3F, 1'b0},
        '{CH_A,     CH_NUL,   CH_NUL,  2'd1, 6'h30, 1'b0},
        '{CH_D,     CH_NUL,   CH_NUL,  2'd1, 6'h0C, 1'b0},
        '{CH_M,     CH_NUL,   CH_NUL,  2'd1, 6'h30, 1'b1},
        '{CH_MINUS, CH_ONE,   CH_NUL,  2'd2, 6'h3A, 1'b0},
        '{CH_BANG,  CH_D,     CH_NUL,  2'd2, 6'h0D, 1'b0},
        '{CH_BANG,  CH_A,     CH_NUL,  2'd2, 6'h31, 1'b0},
        '{CH_BANG,  CH_M,     CH_NUL,  2'd2, 6'h31, 1'b1},
        '{CH_MINUS, CH_D,     CH_NUL,  2'd2, 6'h0F, 1'b0},
        '{CH_MINUS, CH_A,     CH_NUL,  2'd2, 6'h33, 1'b0},
        '{CH_MINUS, CH_M,     CH_NUL,  2'd2, 6'h33, 1'b1},
        '{CH_D,     CH_PLUS,  CH_ONE,  2'd3, 6'h1F, 1'b0},
        '{CH_A,     CH_PLUS,  CH_ONE,  2'd3, 6'h37, 1'b0},
        '{CH_M,     CH_PLUS,  CH_ONE,  2'd3, 6'h37, 1'b1},
        '{CH_D,     CH_MINUS, CH_ONE,  2'd3, 6'h0E, 1'b0},
        '{CH_A,     CH_MINUS, CH_ONE,  2'd3, 6'h32, 1'b0},
        '{CH_M,     CH_MINUS, CH_ONE,  2'd3, 6'h32, 1'b1},
        '{CH_D,     CH_PLUS,  CH_A,    2'd3, 6'h02, 1'b0},
        '{CH_D,     CH_PLUS,  CH_M,    2'd3, 6'h02, 1'b1},
        '{CH_D,     CH_MINUS, CH_A,    2'd3, 6'h13, 1'b0},
        '{CH_D,     CH_MINUS, CH_M,    2'd3, 6'h13, 1'b1},
        '{CH_A,     CH_MINUS, CH_D,    2'd3, 6'h07, 1'b0},
        '{CH_M,     CH_MINUS, CH_D,    2'd3, 6'h07, 1'b1},
        '{CH_D,     CH_AMP,   CH_A,    2'd3, 6'h00, 1'b0},
        '{CH_D,     CH_AMP,   CH_M,    2'd3, 6'h00, 1'b1},
        '{CH_D,     CH_BAR,   CH_A,    2'd3, 6'h15, 1'b0},
        '{CH_D,     CH_BAR,   CH_M,    2'd3, 6'h15, 1'b1}
    };

    // first matching comp entry; a one-character entry needs the second
    // character empty, a two-character entry ignores the third
    function automatic comp_hit_t comp_lookup(input logic [7:0] d0,
                                              input logic [7:0] d1,
                                              input logic [7:0] d2);
        comp_hit_t r;
        logic      m;
        r = '0;
        for (int k = 0; k < COMP_ENTRIES; k++)
        begin
            unique case (COMP_TABLE[k].len)
                2'd1:    m = (d0 == COMP_TABLE[k].c0) && (d1 == CH_NUL);
                2'd2:    m = (d0 == COMP_TABLE[k].c0) && (d1 == COMP_TABLE[k].c1);
                default: m = (d0 == COMP_TABLE[k].c0) && (d1 == COMP_TABLE[k].c1)
                             && (d2 == COMP_TABLE[k].c2);
            endcase
            if (!r.hit && m)
            begin
                r.hit  = 1'b1;
                r.abit = COMP_TABLE[k].abit;
                r.code = COMP_TABLE[k].code;
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/hale_c_encoder.sv
// ----------------------------------------------------------------------------
// hale_c_encoder: C instruction encoder
// Maps the dest, comp and jump tokens of a line onto a word, keeping the
// previous word's bits for any field that is not recognized, but a two-part line clears the field it lacks.
// ----------------------------------------------------------------------------
module hale_c_encoder
(
    input  hale_pkg::tok_view_t view,
    input  logic [15:0]         prev_word,
    output logic [15:0]         word
);

    logic                 two_parts;
    logic                 jump_form;
    logic [2:0][7:0]      t0;
    logic [2:0][7:0]      t1;
    logic [2:0][7:0]      t2;
    logic [2:0]           jump_code;
    logic [2:0]           dest_code;
    logic                 dest_hit;
    hale_pkg::comp_hit_t  comp;

    assign two_parts = ((view.count == 2'd2) && !view.open)
                     || ((view.count == 2'd1) && view.open);
    assign jump_form = two_parts && (view.ch[1][0] == hale_pkg::CH_J);

    // shift tokens into dest/comp/jump slots
    always_comb
    begin
        t0 = view.ch[0];
        t1 = view.ch[1];
        t2 = view.ch[2];
        if (jump_form)
        begin
            t0 = '0;
            t1 = view.ch[0];
            t2 = view.ch[1];
        end
        else if (two_parts)
        begin
            t2 = '0;
        end
    end

    always_comb
    begin
        jump_code = 3'd0;
        priority if (t2[1] == hale_pkg::CH_G && t2[2] == hale_pkg::CH_T) jump_code = 3'd1;
        else if (t2[1] == hale_pkg::CH_E && t2[2] == hale_pkg::CH_Q)     jump_code = 3'd2;
        else if (t2[1] == hale_pkg::CH_G && t2[2] == hale_pkg::CH_E)     jump_code = 3'd3;
        else if (t2[1] == hale_pkg::CH_L && t2[2] == hale_pkg::CH_T)     jump_code = 3'd4;
        else if (t2[1] == hale_pkg::CH_N && t2[2] == hale_pkg::CH_E)     jump_code = 3'd5;
        else if (t2[1] == hale_pkg::CH_L && t2[2] == hale_pkg::CH_E)     jump_code = 3'd6;
        else if (t2[1] == hale_pkg::CH_M && t2[2] == hale_pkg::CH_P)     jump_code = 3'd7;
        else                                                             jump_code = 3'd0;
    end

    always_comb
    begin
        dest_hit  = 1'b1;
        dest_code = 3'd0;
        priority if (t0[0] == hale_pkg::CH_M && t0[1] == hale_pkg::CH_NUL) dest_code = 3'd1;
        else if (t0[0] == hale_pkg::CH_A && t0[1] == hale_pkg::CH_NUL)     dest_code = 3'd4;
        else if (t0[0] == hale_pkg::CH_D && t0[1] == hale_pkg::CH_NUL)     dest_code = 3'd2;
        else if (t0[0] == hale_pkg::CH_M && t0[1] == hale_pkg::CH_D)       dest_code = 3'd3;
        else if (t0[0] == hale_pkg::CH_A && t0[1] == hale_pkg::CH_M
                 && t0[2] != hale_pkg::CH_D)                               dest_code = 3'd5;
        else if (t0[0] == hale_pkg::CH_A && t0[1] == hale_pkg::CH_D)       dest_code = 3'd6;
        else if (t0[0] == hale_pkg::CH_A && t0[1] == hale_pkg::CH_M)       dest_code = 3'd7;
        else                                                               dest_hit  = 1'b0;
    end

    assign comp = hale_pkg::comp_lookup(t1[0], t1[1], t1[2]);

    always_comb
    begin
        word = prev_word | hale_pkg::C_PREFIX;
        if (jump_form)
        begin
            word[5:3] = 3'd0;
        end
        else if (two_parts)
        begin
            word[2:0] = 3'd0;
        end
        if (jump_code != 3'd0)
        begin
            word[2:0] = jump_code;
        end
        if (dest_hit)
        begin
            word[5:3] = dest_code;
        end
        if (comp.hit)
        begin
            word[12:6] = {comp.abit, comp.code};
        end
    end

endmodule

### hw/rtl/hale_line_tracker.sv
// ----------------------------------------------------------------------------
// hale_line_tracker: per-line state
// Classifies each line, accumulates the address, collects tokens and holds
// the previous word; produces the word of an address, fixed or C line when its newline arrives.
// ----------------------------------------------------------------------------
module hale_line_tracker #(
    parameter int TOKEN_CHARS = hale_pkg::TOKEN_CHARS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hale_pkg::char_item_t item,
    input  logic                 advance,
    output logic                 emit_req,
    output logic [15:0]          emit_word
);

    localparam int PW = $clog2(TOKEN_CHARS + 1);

    hale_pkg::line_mode_t   mode_reg,  mode_next;
    logic [14:0]            addr_reg,  addr_next;
    logic                   stop_reg,  stop_next;
    logic [7:0]             tok_reg  [hale_pkg::NUM_TOKENS][TOKEN_CHARS];
    logic [7:0]             tok_next [hale_pkg::NUM_TOKENS][TOKEN_CHARS];
    logic [1:0]             tn_reg,    tn_next;
    logic [PW-1:0]          pos_reg,   pos_next;
    hale_pkg::token_phase_t ph_reg,    ph_next;
    logic [15:0]            prev_reg,  prev_next;

    logic                   step;
    logic [7:0]             c;
    logic                   is_nl;
    logic                   is_sep;
    logic                   is_ws;
    logic                   is_digit;
    logic                   take_en;
    logic [1:0]             tn_tc;
    logic [PW-1:0]          pos_tc;
    hale_pkg::token_phase_t ph_tc;
    logic                   wr_tc;
    hale_pkg::tok_view_t    view;
    logic [15:0]            c_word;

    assign step     = item.valid && advance;
    assign c        = item.ch;
    assign is_nl    = (c == hale_pkg::CH_NL);
    assign is_sep   = (c == hale_pkg::CH_EQ) || (c == hale_pkg::CH_SEMI);
    assign is_ws    = ((c >= hale_pkg::CH_TAB) && (c <= hale_pkg::CH_CR))
                    || (c == hale_pkg::CH_SPACE);
    assign is_digit = (c >= hale_pkg::CH_ZERO) && (c <= hale_pkg::CH_NINE);

    // token collection for one character
    always_comb
    begin
        tn_tc  = tn_reg;
        pos_tc = pos_reg;
        ph_tc  = ph_reg;
        wr_tc  = 1'b0;
        if (is_sep)
        begin
            if (ph_reg != hale_pkg::PH_EMPTY)
            begin
                tn_tc  = (tn_reg == 2'd3) ? 2'd3 : tn_reg + 2'd1;
                pos_tc = '0;
                ph_tc  = hale_pkg::PH_EMPTY;
            end
        end
        else if (is_ws)
        begin
            if (ph_reg == hale_pkg::PH_EMPTY)
            begin
                ph_tc = hale_pkg::PH_SPACE;
            end
            else if (ph_reg == hale_pkg::PH_WORD)
            begin
                ph_tc = hale_pkg::PH_AFTER;
            end
        end
        else if (ph_reg != hale_pkg::PH_AFTER)
        begin
            ph_tc = hale_pkg::PH_WORD;
            if ((tn_reg != 2'd3) && (pos_reg < PW'(TOKEN_CHARS)))
            begin
                wr_tc  = 1'b1;
                pos_tc = pos_reg + PW'(1);
            end
        end
    end

    // next line mode
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            if (mode_reg == hale_pkg::MODE_START)
            begin
                priority if (is_nl)                                    mode_next = mode_reg;
                else if ((c < hale_pkg::LINE_LO) || (c > hale_pkg::LINE_HI))
                                                                        mode_next = hale_pkg::MODE_SKIP;
                else if (c == hale_pkg::CH_AT)                         mode_next = hale_pkg::MODE_ADDR;
                else if (c == hale_pkg::CH_ZERO)                       mode_next = hale_pkg::MODE_FIXED;
                else                                                   mode_next = hale_pkg::MODE_CINST;
            end
            else if (is_nl)
            begin
                mode_next = hale_pkg::MODE_START;
            end
        end
    end

    assign take_en = step && !is_nl
                   && ((mode_reg == hale_pkg::MODE_CINST)
                       || ((mode_reg == hale_pkg::MODE_START)
                           && (c >= hale_pkg::LINE_LO) && (c <= hale_pkg::LINE_HI)
                           && (c != hale_pkg::CH_AT) && (c != hale_pkg::CH_ZERO)));

    // datapath next values
    always_comb
    begin
        addr_next = addr_reg;
        stop_next = stop_reg;
        tok_next  = tok_reg;
        tn_next   = tn_reg;
        pos_next  = pos_reg;
        ph_next   = ph_reg;
        prev_next = prev_reg;
        if (step && is_nl && (mode_reg != hale_pkg::MODE_START))
        begin
            // end of line: clear it
            addr_next = '0;
            stop_next = 1'b0;
            for (int t = 0; t < hale_pkg::NUM_TOKENS; t++)
            begin
                for (int k = 0; k < TOKEN_CHARS; k++)
                begin
                    tok_next[t][k] = '0;
                end
            end
            tn_next  = '0;
            pos_next = '0;
            ph_next  = hale_pkg::PH_EMPTY;
            if (emit_req)
            begin
                prev_next = emit_word;
            end
        end
        else if (step && (mode_reg == hale_pkg::MODE_ADDR))
        begin
            if (!stop_reg && is_digit)
            begin
                addr_next = (addr_reg << 3) + (addr_reg << 1) + {7'd0, c - hale_pkg::CH_ZERO};
            end
            else
            begin
                stop_next = 1'b1;
            end
        end
        else if (take_en)
        begin
            tn_next  = tn_tc;
            pos_next = pos_tc;
            ph_next  = ph_tc;
            for (int t = 0; t < hale_pkg::NUM_TOKENS; t++)
            begin
                for (int k = 0; k < TOKEN_CHARS; k++)
                begin
                    if (wr_tc && (tn_reg == 2'(t)) && (pos_reg == PW'(k)))
                    begin
                        tok_next[t][k] = c;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < hale_pkg::NUM_TOKENS; t++)
        begin
            for (int k = 0; k < hale_pkg::LOOK_CHARS; k++)
            begin
                view.ch[t][k] = tok_reg[t][k];
            end
        end
        view.count = tn_reg;
        view.open  = (ph_reg != hale_pkg::PH_EMPTY);
    end

    hale_c_encoder u_c_encoder
    (
        .view      (view),
        .prev_word (prev_reg),
        .word      (c_word)
    );

    // outputs
    always_comb
    begin
        emit_req = item.valid && is_nl
                 && ((mode_reg == hale_pkg::MODE_ADDR) || (mode_reg == hale_pkg::MODE_FIXED)
                     || (mode_reg == hale_pkg::MODE_CINST));
        unique case (mode_reg)
            hale_pkg::MODE_ADDR:  emit_word = {1'b0, addr_reg};
            hale_pkg::MODE_FIXED: emit_word = hale_pkg::FIXED_WORD;
            default:              emit_word = c_word;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hale_pkg::MODE_START;
            addr_reg <= '0;
            stop_reg <= 1'b0;
            for (int t = 0; t < hale_pkg::NUM_TOKENS; t++)
            begin
                for (int k = 0; k < TOKEN_CHARS; k++)
                begin
                    tok_reg[t][k] <= '0;
                end
            end
            tn_reg   <= '0;
            pos_reg  <= '0;
            ph_reg   <= hale_pkg::PH_EMPTY;
            prev_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            addr_reg <= addr_next;
            stop_reg <= stop_next;
            tok_reg  <= tok_next;
            tn_reg   <= tn_next;
            pos_reg  <= pos_next;
            ph_reg   <= ph_next;
            prev_reg <= prev_next;
        end
    end

endmodule

### hw/rtl/hack_assembly_line_encoder.sv
// ----------------------------------------------------------------------------
// hack_assembly_line_encoder: assembly text to machine word encoder
// A newline item goes into the input register, and the word of its line is then
// loaded into the result register, which drives the result port.
// Throughput: one character per cycle; the input register holds only while
// a finished word waits unread and the character in it ends a line that
// gives a word.
// Reset: clears the line state, the previous word and both registers.
// ----------------------------------------------------------------------------
module hack_assembly_line_encoder #(
    parameter int TOKEN_CHARS = hale_pkg::TOKEN_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] machine_word
);

    // input register: one character waiting to update the line state
    hale_pkg::char_item_t in_reg, in_next;

    // result register: one finished word waiting to be taken
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_word_reg,  out_word_next;

    logic        emit_req;
    logic [15:0] emit_word;
    logic        advance;

    // hold the character only when it would emit into a full result slot that is not taken
    assign advance       = !(emit_req && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !in_reg.valid || advance;

    always_comb
    begin
        in_next = in_reg;
        if (s_axis_tready)
        begin
            in_next.valid = s_axis_tvalid;
            in_next.ch    = s_axis_tdata;
        end
    end

    hale_line_tracker #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_line_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_reg),
        .advance   (advance),
        .emit_req  (emit_req),
        .emit_word (emit_word)
    );

    // load a new word when one is emitted, drop the old one when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit_req && advance)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            in_reg        <= in_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;

endmodule

### hw/rtl/hale_checker.sv
// ----------------------------------------------------------------------------
// hale_checker: port-level checks for the assembly line encoder
// Watches the stream ports over time; attached by the bind at the end.
// ----------------------------------------------------------------------------
module hale_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a result waiting unread stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its word
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // input backpressure only comes from a full, unread result slot
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // reset empties the result slot at once
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

endmodule

bind hack_assembly_line_encoder hale_checker u_hale_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/tb_hack_assembly_line_encoder.sv
// ----------------------------------------------------------------------------
// tb_hack_assembly_line_encoder: self-checking bench for the line encoder
// Streams assembly text into the encoder one character per item: a few
// hand-picked lines first, then random address, fixed, C-instruction, skipped,
// noise and empty lines. A scoreboard tracks the line state the same way the
// block does, predicts each machine word and checks every word that comes out.
// Both stream sides idle at random, and the result side holds off once for a
// long stretch so that the encoder backs up into its input.
// ----------------------------------------------------------------------------
module tb_hack_assembly_line_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOK_LEN      = hale_pkg::TOKEN_CHARS_DEF;
    localparam int TEXT_ITEMS   = 1950;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no item moving on either side
    localparam int SQUEEZE_AT   = 400;    // characters sent before the long hold-off
    localparam int SQUEEZE_LEN  = 300;
    localparam int DRAIN_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the per-line state, predicts words, checks results
    // ------------------------------------------------------------------------
    class hack_word_scoreboard;

        hale_pkg::line_mode_t   mode;
        logic [14:0]            addr_acc;
        bit                     addr_done;
        logic [7:0]             tokens [hale_pkg::NUM_TOKENS][TOK_LEN];
        int                     tok_count;
        int                     tok_pos;
        hale_pkg::token_phase_t phase;
        logic [15:0]            last_word;
        logic [15:0]            pending_words [$];
        int                     mismatches;

        function new();
            last_word  = '0;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = hale_pkg::MODE_START;
            addr_acc  = '0;
            addr_done = 1'b0;
            tok_count = 0;
            tok_pos   = 0;
            phase     = hale_pkg::PH_EMPTY;
            foreach (tokens[t, k])
                tokens[t][k] = hale_pkg::CH_NUL;
        endfunction

        function logic [7:0] tok_at(int t, int k);
            if (t >= hale_pkg::NUM_TOKENS || k >= TOK_LEN)
                return hale_pkg::CH_NUL;
            return tokens[t][k];
        endfunction

        // split on '=' and ';', keep the first word of each segment
        function void take_char(logic [7:0] c);
            if (c == hale_pkg::CH_EQ || c == hale_pkg::CH_SEMI)
            begin
                if (phase != hale_pkg::PH_EMPTY)
                begin
                    if (tok_count < hale_pkg::NUM_TOKENS)
                        tok_count++;
                    tok_pos = 0;
                    phase   = hale_pkg::PH_EMPTY;
                end
                return;
            end
            if ((c >= 8'd9 && c <= 8'd13) || c == hale_pkg::CH_SPACE)
            begin
                if (phase == hale_pkg::PH_EMPTY)
                    phase = hale_pkg::PH_SPACE;
                else if (phase == hale_pkg::PH_WORD)
                    phase = hale_pkg::PH_AFTER;
                return;
            end
            if (phase == hale_pkg::PH_AFTER)
                return;
            phase = hale_pkg::PH_WORD;
            if (tok_count < hale_pkg::NUM_TOKENS && tok_pos < TOK_LEN)
            begin
                tokens[tok_count][tok_pos] = c;
                tok_pos++;
            end
        endfunction

        // bit 7 flags a hit; bits 6..0 are the a bit and the six comp bits
        function logic [7:0] comp_bits(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            logic [7:0] r;
            r = 8'h00;
            if (c1 == hale_pkg::CH_NUL)
            begin
                case (c0)
                    "0":     r = 8'h80 | 8'h2A;
                    "1":     r = 8'h80 | 8'h3F;
                    "A":     r = 8'h80 | 8'h30;
                    "D":     r = 8'h80 | 8'h0C;
                    "M":     r = 8'h80 | 8'h70;
                    default: r = 8'h00;
                endcase
            end
            else if (c0 == hale_pkg::CH_MINUS || c0 == hale_pkg::CH_BANG)
            begin
                case ({c0, c1})
                    "-1":    r = 8'h80 | 8'h3A;
                    "!D":    r = 8'h80 | 8'h0D;
                    "!A":    r = 8'h80 | 8'h31;
                    "!M":    r = 8'h80 | 8'h71;
                    "-D":    r = 8'h80 | 8'h0F;
                    "-A":    r = 8'h80 | 8'h33;
                    "-M":    r = 8'h80 | 8'h73;
                    default: r = 8'h00;
                endcase
            end
            else
            begin
                case ({c0, c1, c2})
                    "D+1":   r = 8'h80 | 8'h1F;
                    "A+1":   r = 8'h80 | 8'h37;
                    "M+1":   r = 8'h80 | 8'h77;
                    "D-1":   r = 8'h80 | 8'h0E;
                    "A-1":   r = 8'h80 | 8'h32;
                    "M-1":   r = 8'h80 | 8'h72;
                    "D+A":   r = 8'h80 | 8'h02;
                    "D+M":   r = 8'h80 | 8'h42;
                    "D-A":   r = 8'h80 | 8'h13;
                    "D-M":   r = 8'h80 | 8'h53;
                    "A-D":   r = 8'h80 | 8'h07;
                    "M-D":   r = 8'h80 | 8'h47;
                    "D&A":   r = 8'h80 | 8'h00;
                    "D&M":   r = 8'h80 | 8'h40;
                    "D|A":   r = 8'h80 | 8'h15;
                    "D|M":   r = 8'h80 | 8'h55;
                    default: r = 8'h00;
                endcase
            end
            return r;
        endfunction

        // advance the line state by one accepted character
        function void note_char(logic [7:0] c);
            int          acc;
            int          parts;
            logic [15:0] w;
            logic [2:0]  jbits;
            logic [2:0]  dbits;
            logic [7:0]  cb;
            logic [23:0] d;

            if (mode == hale_pkg::MODE_START)
            begin
                if (c < hale_pkg::LINE_LO || c > hale_pkg::LINE_HI)
                    mode = hale_pkg::MODE_SKIP;
                else if (c == hale_pkg::CH_AT)
                    mode = hale_pkg::MODE_ADDR;
                else if (c == hale_pkg::CH_ZERO)
                    mode = hale_pkg::MODE_FIXED;
                else
                    mode = hale_pkg::MODE_CINST;
                if (mode == hale_pkg::MODE_CINST)
                    take_char(c);
                if (c != hale_pkg::CH_NL)
                    return;
            end
            else if (c != hale_pkg::CH_NL)
            begin
                if (mode == hale_pkg::MODE_ADDR)
                begin
                    if (!addr_done && c >= hale_pkg::CH_ZERO && c <= hale_pkg::CH_NINE)
                    begin
                        acc      = int'(addr_acc) * 10 + int'(c - hale_pkg::CH_ZERO);
                        addr_acc = acc[14:0];
                    end
                    else
                        addr_done = 1'b1;
                end
                else if (mode == hale_pkg::MODE_CINST)
                    take_char(c);
                return;
            end

            // newline: finish the line
            if (mode == hale_pkg::MODE_ADDR)
            begin
                last_word = {1'b0, addr_acc};
                pending_words.push_back(last_word);
            end
            else if (mode == hale_pkg::MODE_FIXED)
            begin
                last_word = hale_pkg::FIXED_WORD;
                pending_words.push_back(last_word);
            end
            else if (mode == hale_pkg::MODE_CINST)
            begin
                w     = last_word | hale_pkg::C_PREFIX;
                parts = tok_count + ((phase != hale_pkg::PH_EMPTY) ? 1 : 0);

                // two tokens: comp;jump when the second starts with J, else dest=comp
                if (parts == 2)
                begin
                    if (tok_at(1, 0) == hale_pkg::CH_J)
                    begin
                        for (int k = 0; k < TOK_LEN; k++)
                        begin
                            tokens[2][k] = tokens[1][k];
                            tokens[1][k] = tokens[0][k];
                            tokens[0][k] = hale_pkg::CH_NUL;
                        end
                        w[5:3] = 3'b000;
                    end
                    else
                    begin
                        for (int k = 0; k < TOK_LEN; k++)
                            tokens[2][k] = hale_pkg::CH_NUL;
                        w[2:0] = 3'b000;
                    end
                end

                // jump looks at characters 1 and 2 only
                case ({tok_at(2, 1), tok_at(2, 2)})
                    "GT":    jbits = 3'd1;
                    "EQ":    jbits = 3'd2;
                    "GE":    jbits = 3'd3;
                    "LT":    jbits = 3'd4;
                    "NE":    jbits = 3'd5;
                    "LE":    jbits = 3'd6;
                    "MP":    jbits = 3'd7;
                    default: jbits = 3'd0;
                endcase
                if (jbits != 3'd0)
                    w[2:0] = jbits;

                d     = {tok_at(0, 0), tok_at(0, 1), tok_at(0, 2)};
                dbits = 3'd0;
                if (d[15:8] == hale_pkg::CH_NUL)
                begin
                    case (d[23:16])
                        "M":     dbits = 3'd1;
                        "A":     dbits = 3'd4;
                        "D":     dbits = 3'd2;
                        default: dbits = 3'd0;
                    endcase
                end
                else
                begin
                    case (d[23:8])
                        "MD":    dbits = 3'd3;
                        "AD":    dbits = 3'd6;
                        "AM":    dbits = (d[7:0] == hale_pkg::CH_D) ? 3'd7 : 3'd5;
                        default: dbits = 3'd0;
                    endcase
                end
                if (dbits != 3'd0)
                    w[5:3] = dbits;

                cb = comp_bits(tok_at(1, 0), tok_at(1, 1), tok_at(1, 2));
                if (cb[7])
                    w[12:6] = cb[6:0];

                last_word = w;
                pending_words.push_back(last_word);
            end
            clear_line();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_word(logic [15:0] got);
            logic [15:0] want;
            if (pending_words.size() == 0)
                report_mismatch($sformatf("machine_word %h with no line pending", got));
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("machine_word %h, predicted %h", got, want));
            end
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] text_char
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [15:0] machine_word

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hack_assembly_line_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hack_word_scoreboard sb;
    logic [7:0]          line_chars [$];
    int                  chars_sent = 0;
    bit                  squeezed   = 1'b0;
    bit                  burst_line = 1'b0;
    int                  quiet_cycles = 0;

    string dest_names [7] = '{"M", "D", "MD", "A", "AM", "AD", "AMD"};
    string jump_names [7] = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
    string comp_names [28] = '{
        "0", "1", "A", "D", "M", "-1", "!D", "!A", "!M", "-D", "-A", "-M",
        "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "D+M", "D-A", "D-M",
        "A-D", "M-D", "D&A", "D&M", "D|A", "D|M"
    };
    string junk_pool = "ADMJ01+-!&|GTEQLNP";

    // mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Text building
    // ------------------------------------------------------------------------
    task add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    // random word: mostly mnemonic letters, now and then any byte but newline
    task add_junk(int max_len);
        logic [7:0] c;
        repeat ($urandom_range(1, max_len))
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == hale_pkg::CH_NL)
                    c = hale_pkg::CH_NUL;
            end
            else
                c = junk_pool[$urandom_range(0, junk_pool.len() - 1)];
            line_chars.push_back(c);
        end
    endtask

    // occasional whitespace between tokens
    task add_blank();
        logic [7:0] ws [5];
        ws = '{8'd9, 8'd11, 8'd12, 8'd13, hale_pkg::CH_SPACE};
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
                line_chars.push_back(ws[$urandom_range(0, 4)]);
    endtask

    // well-formed dest=comp;jump skeleton with random parts broken or extended
    task add_c_fields();
        if ($urandom_range(0, 9) < 6)
        begin
            if ($urandom_range(0, 6) == 0)
                add_junk(5);
            else
                add_text(dest_names[$urandom_range(0, 6)]);
            add_blank();
            line_chars.push_back(hale_pkg::CH_EQ);
            add_blank();
        end
        if ($urandom_range(0, 6) == 0)
            add_junk(5);
        else
            add_text(comp_names[$urandom_range(0, 27)]);
        if ($urandom_range(0, 14) == 0)
        begin
            // second word in the same segment is dropped
            line_chars.push_back(hale_pkg::CH_SPACE);
            add_junk(3);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            add_blank();
            line_chars.push_back(hale_pkg::CH_SEMI);
            add_blank();
            if ($urandom_range(0, 6) == 0)
                add_junk(5);
            else
                add_text(jump_names[$urandom_range(0, 6)]);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            // extra or empty segments
            line_chars.push_back($urandom_range(0, 1) ? hale_pkg::CH_SEMI : hale_pkg::CH_EQ);
            if ($urandom_range(0, 2) != 0)
                add_junk(4);
        end
        add_blank();
    endtask

    task build_line();
        int         kind;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            line_chars.push_back(hale_pkg::CH_AT);
            repeat ($urandom_range(0, 7))
                line_chars.push_back(hale_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0)
                add_junk(4);
        end
        else if (kind < 20)
        begin
            line_chars.push_back(hale_pkg::CH_ZERO);
            if ($urandom_range(0, 1) == 0)
                add_junk(4);
        end
        else if (kind < 75)
            add_c_fields();
        else if (kind < 85)
        begin
            // first character outside '0'..'Z' skips the whole line
            c = 8'($urandom_range(0, 255 - 43));
            if (c >= hale_pkg::LINE_LO)
                c = c + 8'd43;
            line_chars.push_back(c);
            if ($urandom_range(0, 1) == 0)
                add_c_fields();
        end
        else if (kind < 95)
        begin
            repeat ($urandom_range(0, 8))
                line_chars.push_back(8'($urandom_range(0, 255)));
        end
        line_chars.push_back(hale_pkg::CH_NL);
    endtask

    // ------------------------------------------------------------------------
    // Character driver: change inputs at the falling edge, take at the rising
    // ------------------------------------------------------------------------
    task send_char(logic [7:0] c);
        int gap;
        gap = burst_line ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    task send_queued();
        burst_line = ($urandom_range(0, 3) == 0);
        while (line_chars.size() > 0)
            send_char(line_chars.pop_front());
    endtask

    initial
    begin : text_source
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: address wrap, fixed word, empty line, all three fields,
        // comp;jump with dest cleared
        add_text("@99999\n");
        add_text("0\n");
        add_text("\n");
        add_text("AMD=D|M;JGE\n");
        add_text("D;JLT\n");
        send_queued();

        while (chars_sent < TEXT_ITEMS)
        begin
            build_line();
            send_queued();
        end

        // unterminated last line: no word may come out for it
        add_text("AMD");
        send_queued();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random ready, one long hold-off to back up the input
    // ------------------------------------------------------------------------
    initial
    begin : word_sink
        int span;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeezed && chars_sent >= SQUEEZE_AT)
            begin
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                span = SQUEEZE_LEN;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                span = idle_gap() + 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                span = $urandom_range(1, 40);
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    // check each word as it is taken
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no item moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
